>>> design/rhc_pkg.sv
// shared types for the rgb/hsv color converter
`default_nettype none
package rhc_pkg;

   // control word that travels with each pixel down the pipeline
   typedef struct packed {
      logic valid;   // stage holds a pixel
      logic mode;    // 0 rgb to hsv, 1 hsv to rgb
      logic black;   // forward: max channel is zero
      logic grey;    // forward: max equals min
   } rhc_ctl_type;

   localparam logic MODE_FORWARD = 1'b0;
   localparam logic MODE_REVERSE = 1'b1;

endpackage
`default_nettype wire

>>> design/rhc_front.sv
// front end: input saturation, forward divider setup and reverse p/q/t products
`default_nettype none
module rhc_front #(
   parameter int FRAC_BITS = 16
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        advance,
   input  wire                        in_valid,
   input  wire                        mode,
   input  wire  [FRAC_BITS:0]         in_a,
   input  wire  [FRAC_BITS:0]         in_b,
   input  wire  [FRAC_BITS:0]         in_c,
   output rhc_pkg::rhc_ctl_type       ctl_out,
   output logic [FRAC_BITS+3:0]       rem_s_out,
   output logic [FRAC_BITS+3:0]       den_s_out,
   output logic [FRAC_BITS+3:0]       rem_h_out,
   output logic [FRAC_BITS+3:0]       den_h_out,
   output logic [FRAC_BITS:0]         aux0_out,
   output logic [FRAC_BITS:0]         aux1_out,
   output logic [FRAC_BITS:0]         aux2_out
);
   import rhc_pkg::*;

   localparam int W  = FRAC_BITS + 1;
   localparam int DW = FRAC_BITS + 4;
   localparam int NW = FRAC_BITS + 5;
   localparam logic [W-1:0] ONE_W = W'(1) << FRAC_BITS;

   localparam logic [2:0] SECTOR_0 = 3'd0;
   localparam logic [2:0] SECTOR_1 = 3'd1;
   localparam logic [2:0] SECTOR_2 = 3'd2;
   localparam logic [2:0] SECTOR_3 = 3'd3;
   localparam logic [2:0] SECTOR_4 = 3'd4;

   // stage a registers
   rhc_ctl_type             a_ctl_ff, a_ctl_in;
   logic [W-1:0]            a_mx_ff, a_mx_in;
   logic [W-1:0]            a_c_ff, a_c_in;
   logic [DW-1:0]           a_n_ff, a_n_in;
   logic [W-1:0]            a_v_ff, a_v_in;
   logic [2:0]              a_sector_ff, a_sector_in;
   logic [W-1:0]            a_p_ff, a_p_in;
   logic [W-1:0]            a_sf_ff, a_sf_in;
   logic [W-1:0]            a_s1f_ff, a_s1f_in;

   // stage b registers
   rhc_ctl_type             b_ctl_ff, b_ctl_in;
   logic [DW-1:0]           b_rem_s_ff, b_rem_s_in;
   logic [DW-1:0]           b_den_s_ff, b_den_s_in;
   logic [DW-1:0]           b_rem_h_ff, b_rem_h_in;
   logic [DW-1:0]           b_den_h_ff, b_den_h_in;
   logic [W-1:0]            b_aux0_ff, b_aux0_in;
   logic [W-1:0]            b_aux1_ff, b_aux1_in;
   logic [W-1:0]            b_aux2_ff, b_aux2_in;

   logic [W-1:0]            sat_r, sat_g, sat_b;
   logic [W-1:0]            mx, mn, chroma;
   logic [NW-1:0]           n_raw, n_six;
   logic [FRAC_BITS-1:0]    hue;
   logic [FRAC_BITS+2:0]    h6;
   logic [FRAC_BITS-1:0]    frac;
   logic [2*W-1:0]          prod_p, prod_sf, prod_s1f, prod_q, prod_t;
   logic [W-1:0]            q_val, t_val;
   logic [DW-1:0]           six_c;

   // clamp channels above one
   always_comb begin
      sat_r = (in_a > ONE_W) ? ONE_W : in_a;
      sat_g = (in_b > ONE_W) ? ONE_W : in_b;
      sat_b = (in_c > ONE_W) ? ONE_W : in_c;
   end

   // forward: max, min, chroma and hue numerator in units of chroma
   always_comb begin
      mx = sat_r;
      if (sat_g > mx) mx = sat_g;
      if (sat_b > mx) mx = sat_b;
      mn = sat_r;
      if (sat_g < mn) mn = sat_g;
      if (sat_b < mn) mn = sat_b;
      chroma = mx - mn;
      n_six  = ({4'b0000, chroma} << 2) + ({4'b0000, chroma} << 1);
      priority if (mx == sat_b) begin
         n_raw = ({4'b0000, chroma} << 2) + {4'b0000, sat_r} - {4'b0000, sat_g};
      end else if (mx == sat_g) begin
         n_raw = ({4'b0000, chroma} << 1) + {4'b0000, sat_b} - {4'b0000, sat_r};
      end else begin
         n_raw = {4'b0000, sat_g} - {4'b0000, sat_b};
      end
      if (n_raw[NW-1]) n_raw = n_raw + n_six;
   end

   // reverse: sector, fraction and first products
   always_comb begin
      hue      = in_a[FRAC_BITS-1:0];
      h6       = ({3'b000, hue} << 2) + ({3'b000, hue} << 1);
      frac     = h6[FRAC_BITS-1:0];
      prod_p   = sat_b * (ONE_W - sat_g);
      prod_sf  = sat_g * {1'b0, frac};
      prod_s1f = sat_g * (ONE_W - {1'b0, frac});
   end

   always_comb begin
      a_ctl_in.valid = in_valid;
      a_ctl_in.mode  = mode;
      a_ctl_in.black = (mx == '0);
      a_ctl_in.grey  = (chroma == '0);
      a_mx_in        = mx;
      a_c_in         = chroma;
      a_n_in         = n_raw[DW-1:0];
      a_v_in         = sat_b;
      a_sector_in    = h6[FRAC_BITS+2:FRAC_BITS];
      a_p_in         = prod_p[2*FRAC_BITS:FRAC_BITS];
      a_sf_in        = prod_sf[2*FRAC_BITS:FRAC_BITS];
      a_s1f_in       = prod_s1f[2*FRAC_BITS:FRAC_BITS];
   end

   // reverse: q and t, then sector select; forward: divider operands and max channel as value
   always_comb begin
      prod_q = a_v_ff * (ONE_W - a_sf_ff);
      prod_t = a_v_ff * (ONE_W - a_s1f_ff);
      q_val  = prod_q[2*FRAC_BITS:FRAC_BITS];
      t_val  = prod_t[2*FRAC_BITS:FRAC_BITS];
      six_c  = ({3'b000, a_c_ff} << 2) + ({3'b000, a_c_ff} << 1);

      b_ctl_in   = a_ctl_ff;
      b_rem_s_in = {3'b000, a_c_ff};
      b_den_s_in = {3'b000, a_mx_ff};
      b_rem_h_in = a_n_ff;
      b_den_h_in = six_c;
      if (a_ctl_ff.mode == MODE_REVERSE) begin
         unique case (a_sector_ff)
            SECTOR_0: begin b_aux0_in = a_v_ff; b_aux1_in = t_val;  b_aux2_in = a_p_ff; end
            SECTOR_1: begin b_aux0_in = q_val;  b_aux1_in = a_v_ff; b_aux2_in = a_p_ff; end
            SECTOR_2: begin b_aux0_in = a_p_ff; b_aux1_in = a_v_ff; b_aux2_in = t_val;  end
            SECTOR_3: begin b_aux0_in = a_p_ff; b_aux1_in = q_val;  b_aux2_in = a_v_ff; end
            SECTOR_4: begin b_aux0_in = t_val;  b_aux1_in = a_p_ff; b_aux2_in = a_v_ff; end
            default:  begin b_aux0_in = a_v_ff; b_aux1_in = a_p_ff; b_aux2_in = q_val;  end
         endcase
      end else begin
         b_aux0_in = '0;
         b_aux1_in = '0;
         b_aux2_in = a_mx_ff;
      end
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
         b_ctl_ff <= '0;
      end else if (advance) begin
         a_ctl_ff <= a_ctl_in;
         b_ctl_ff <= b_ctl_in;
      end
      if (advance) begin
         a_mx_ff     <= a_mx_in;
         a_c_ff      <= a_c_in;
         a_n_ff      <= a_n_in;
         a_v_ff      <= a_v_in;
         a_sector_ff <= a_sector_in;
         a_p_ff      <= a_p_in;
         a_sf_ff     <= a_sf_in;
         a_s1f_ff    <= a_s1f_in;
         b_rem_s_ff  <= b_rem_s_in;
         b_den_s_ff  <= b_den_s_in;
         b_rem_h_ff  <= b_rem_h_in;
         b_den_h_ff  <= b_den_h_in;
         b_aux0_ff   <= b_aux0_in;
         b_aux1_ff   <= b_aux1_in;
         b_aux2_ff   <= b_aux2_in;
      end
   end

   assign ctl_out   = b_ctl_ff;
   assign rem_s_out = b_rem_s_ff;
   assign den_s_out = b_den_s_ff;
   assign rem_h_out = b_rem_h_ff;
   assign den_h_out = b_den_h_ff;
   assign aux0_out  = b_aux0_ff;
   assign aux1_out  = b_aux1_ff;
   assign aux2_out  = b_aux2_ff;

endmodule
`default_nettype wire

>>> design/rhc_cell.sv
// one divider cell: a restoring step for the saturation and hue quotients
`default_nettype none
module rhc_cell #(
   parameter int FRAC_BITS = 16
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        advance,
   input  rhc_pkg::rhc_ctl_type       ctl_in,
   input  wire  [FRAC_BITS+3:0]       rem_s_in,
   input  wire  [FRAC_BITS+3:0]       den_s_in,
   input  wire  [FRAC_BITS:0]         quo_s_in,
   input  wire  [FRAC_BITS+3:0]       rem_h_in,
   input  wire  [FRAC_BITS+3:0]       den_h_in,
   input  wire  [FRAC_BITS:0]         quo_h_in,
   input  wire  [FRAC_BITS:0]         aux0_in,
   input  wire  [FRAC_BITS:0]         aux1_in,
   input  wire  [FRAC_BITS:0]         aux2_in,
   output rhc_pkg::rhc_ctl_type       ctl_out,
   output logic [FRAC_BITS+3:0]       rem_s_out,
   output logic [FRAC_BITS+3:0]       den_s_out,
   output logic [FRAC_BITS:0]         quo_s_out,
   output logic [FRAC_BITS+3:0]       rem_h_out,
   output logic [FRAC_BITS+3:0]       den_h_out,
   output logic [FRAC_BITS:0]         quo_h_out,
   output logic [FRAC_BITS:0]         aux0_out,
   output logic [FRAC_BITS:0]         aux1_out,
   output logic [FRAC_BITS:0]         aux2_out
);
   import rhc_pkg::*;

   localparam int W  = FRAC_BITS + 1;
   localparam int DW = FRAC_BITS + 4;

   rhc_ctl_type     ctl_ff;
   logic [DW-1:0]   rem_s_ff, rem_s_in2, den_s_ff, rem_h_ff, rem_h_in2, den_h_ff;
   logic [W-1:0]    quo_s_ff, quo_s_in2, quo_h_ff, quo_h_in2;
   logic [W-1:0]    aux0_ff, aux1_ff, aux2_ff;
   logic            ge_s, ge_h;
   logic [DW-1:0]   diff_s, diff_h;

   // compare, subtract, shift one quotient bit in
   always_comb begin
      ge_s      = (rem_s_in >= den_s_in);
      ge_h      = (rem_h_in >= den_h_in);
      diff_s    = ge_s ? (rem_s_in - den_s_in) : rem_s_in;
      diff_h    = ge_h ? (rem_h_in - den_h_in) : rem_h_in;
      rem_s_in2 = diff_s << 1;
      rem_h_in2 = diff_h << 1;
      quo_s_in2 = {quo_s_in[W-2:0], ge_s};
      quo_h_in2 = {quo_h_in[W-2:0], ge_h};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
      if (advance) begin
         rem_s_ff <= rem_s_in2;
         den_s_ff <= den_s_in;
         quo_s_ff <= quo_s_in2;
         rem_h_ff <= rem_h_in2;
         den_h_ff <= den_h_in;
         quo_h_ff <= quo_h_in2;
         aux0_ff  <= aux0_in;
         aux1_ff  <= aux1_in;
         aux2_ff  <= aux2_in;
      end
   end

   assign ctl_out   = ctl_ff;
   assign rem_s_out = rem_s_ff;
   assign den_s_out = den_s_ff;
   assign quo_s_out = quo_s_ff;
   assign rem_h_out = rem_h_ff;
   assign den_h_out = den_h_ff;
   assign quo_h_out = quo_h_ff;
   assign aux0_out  = aux0_ff;
   assign aux1_out  = aux1_ff;
   assign aux2_out  = aux2_ff;

endmodule
`default_nettype wire

>>> design/rgb_hsv_color_converter.sv
// top level of the rgb/hsv color converter
//
// Converts one pixel per transfer between RGB and HSV. csr_wr_data selects
// the direction (0 rgb to hsv, 1 hsv to rgb) and is written on csr_wr_en;
// it resets to rgb to hsv. Channels are fixed point with FRAC_BITS fraction
// bits, one pixel enters on req_* and one result leaves on rsp_*.
// The pipeline holds two front stages, a chain of FRAC_BITS + 1 divider
// cells that each settle one quotient bit of saturation and hue, and the
// output register. A new pixel can be taken every cycle unless the output
// stalls. The whole pipeline moves together: when the receiver holds
// rsp_ready low with a result waiting, req_ready drops and every stage
// holds. Reset empties the pipeline and clears the direction register.
`default_nettype none
module rgb_hsv_color_converter #(
   parameter int FRAC_BITS = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  csr_wr_en,
   input  wire                  csr_wr_data,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire  [FRAC_BITS:0]   req_in_red_or_hue,
   input  wire  [FRAC_BITS:0]   req_in_green_or_sat,
   input  wire  [FRAC_BITS:0]   req_in_blue_or_value,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic [FRAC_BITS:0]   rsp_out_hue_or_red,
   output logic [FRAC_BITS:0]   rsp_out_sat_or_green,
   output logic [FRAC_BITS:0]   rsp_out_value_or_blue
);
   import rhc_pkg::*;

   localparam int W  = FRAC_BITS + 1;
   localparam int DW = FRAC_BITS + 4;
   localparam logic [W-1:0] HUE_MAX = (W'(1) << FRAC_BITS) - W'(1);

   logic            direction_ff;
   logic            advance;
   logic            rsp_valid_ff;
   logic [W-1:0]    out0_ff, out0_in, out1_ff, out1_in, out2_ff;

   rhc_ctl_type     ctl   [0:W];
   logic [DW-1:0]   rem_s [0:W];
   logic [DW-1:0]   den_s [0:W];
   logic [W-1:0]    quo_s [0:W];
   logic [DW-1:0]   rem_h [0:W];
   logic [DW-1:0]   den_h [0:W];
   logic [W-1:0]    quo_h [0:W];
   logic [W-1:0]    aux0  [0:W];
   logic [W-1:0]    aux1  [0:W];
   logic [W-1:0]    aux2  [0:W];

   // whole pipeline steps when the output slot is free or being drained
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // direction register
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= MODE_FORWARD;
      end else if (csr_wr_en) begin
         direction_ff <= csr_wr_data;
      end
   end

   rhc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .mode      (direction_ff),
      .in_a      (req_in_red_or_hue),
      .in_b      (req_in_green_or_sat),
      .in_c      (req_in_blue_or_value),
      .ctl_out   (ctl[0]),
      .rem_s_out (rem_s[0]),
      .den_s_out (den_s[0]),
      .rem_h_out (rem_h[0]),
      .den_h_out (den_h[0]),
      .aux0_out  (aux0[0]),
      .aux1_out  (aux1[0]),
      .aux2_out  (aux2[0])
   );

   assign quo_s[0] = '0;
   assign quo_h[0] = '0;

   // divider chain, one quotient bit per cell
   for (genvar k = 0; k < W; k++) begin : g_cell
      rhc_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .ctl_in    (ctl[k]),
         .rem_s_in  (rem_s[k]),
         .den_s_in  (den_s[k]),
         .quo_s_in  (quo_s[k]),
         .rem_h_in  (rem_h[k]),
         .den_h_in  (den_h[k]),
         .quo_h_in  (quo_h[k]),
         .aux0_in   (aux0[k]),
         .aux1_in   (aux1[k]),
         .aux2_in   (aux2[k]),
         .ctl_out   (ctl[k+1]),
         .rem_s_out (rem_s[k+1]),
         .den_s_out (den_s[k+1]),
         .quo_s_out (quo_s[k+1]),
         .rem_h_out (rem_h[k+1]),
         .den_h_out (den_h[k+1]),
         .quo_h_out (quo_h[k+1]),
         .aux0_out  (aux0[k+1]),
         .aux1_out  (aux1[k+1]),
         .aux2_out  (aux2[k+1])
      );
   end

   // final select: reverse passes the selected products; forward: grey and black special cases, hue saturation
   always_comb begin
      if (ctl[W].mode == MODE_REVERSE) begin
         out0_in = aux0[W];
         out1_in = aux1[W];
      end else begin
         if (ctl[W].grey) out0_in = '0;
         else if (quo_h[W][FRAC_BITS]) out0_in = HUE_MAX;
         else out0_in = quo_h[W];
         out1_in = ctl[W].black ? '0 : quo_s[W];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= ctl[W].valid;
      end
      if (advance) begin
         out0_ff <= out0_in;
         out1_ff <= out1_in;
         out2_ff <= aux2[W];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_out_hue_or_red    = out0_ff;
   assign rsp_out_sat_or_green  = out1_ff;
   assign rsp_out_value_or_blue = out2_ff;

endmodule
`default_nettype wire
